// ===== hw/rtl/sqrb_pkg.sv =====
// ----------------------------------------------------------------------------
// sqrb_pkg: shared types and helpers for the sprite quad bounds block
// Holds the quarter-wave sine table builder, trig address mapping, the beat
// type that passes from front to back, and the rounding and clamp helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package sqrb_pkg;

  // Quarter-wave table depth and the address width that reaches entry DEPTH.
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH + 1);

  // Datapath widths.
  localparam int TRIG_W = 18;  // signed sine or cosine, Q.16 in -1..1
  localparam int HALF_W = 28;  // half extent, width times Q8.8 scale
  localparam int RW     = 52;  // working width of the rounding helpers

  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
  localparam longint Q8_MAX = 64'sd8388607;
  localparam longint Q8_MIN = -64'sd8388608;

  typedef logic [16:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  // One table lookup: mirrored address and the sign of the quadrant.
  typedef struct packed {
    logic             neg;
    logic [IDX_W-1:0] idx;
  } trig_addr_t;

  // Beat that travels from the front end through the queue.
  typedef struct packed {
    logic               present;
    logic [HALF_W-1:0]  hx;
    logic [HALF_W-1:0]  hy;
    logic signed [23:0] px;
    logic signed [23:0] py;
    trig_addr_t         sx;
    trig_addr_t         cx;
    trig_addr_t         sy;
    trig_addr_t         cy;
    trig_addr_t         sz;
    trig_addr_t         cz;
  } q_item_t;

  // Sine table in Q.16, from a Q30 Taylor series through the 15th power.
  // Evaluated during elaboration, once per ROM instance.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t         tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   sum;
    longint unsigned   q16;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (Q30_HALF_PI * 64'(k)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      q16 = (sum + 64'd8192) >> 14;
      if (q16 > 64'd65536) begin
        q16 = 64'd65536;
      end
      tab[k] = q16[16:0];
    end
    return tab;
  endfunction

  // Map a binary angle onto a quarter-wave address and a sign.
  function automatic trig_addr_t trig_addr(input logic [15:0] ang);
    trig_addr_t          t;
    logic [13+IDX_W:0]   prod;
    logic [IDX_W-1:0]    idx;
    prod  = (14 + IDX_W)'(ang[13:0]) * (14 + IDX_W)'(SINE_TABLE_DEPTH);
    idx   = prod[13+IDX_W:14];
    t.neg = ang[15];
    t.idx = ang[14] ? (IDX_W'(SINE_TABLE_DEPTH) - idx) : idx;
    return t;
  endfunction

  // Right shift by 16 that rounds half away from zero.
  function automatic logic signed [RW-1:0] rnd16(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] m;
    m = -v;
    if (v >= 0) begin
      return $signed((v + RW'(32768)) >> 16);
    end
    return -$signed((m + RW'(32768)) >> 16);
  endfunction

  // Right shift by 1 that rounds half away from zero.
  function automatic logic signed [RW-1:0] rnd1(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] m;
    m = -v;
    if (v >= 0) begin
      return $signed((v + RW'(1)) >> 1);
    end
    return -$signed((m + RW'(1)) >> 1);
  endfunction

  // Clamp to a signed Q16.8 field.
  function automatic logic [23:0] sat_s24(input logic signed [RW-1:0] v);
    if (v > Q8_MAX) begin
      return 24'h7FFFFF;
    end
    if (v < Q8_MIN) begin
      return 24'h800000;
    end
    return v[23:0];
  endfunction

  // Clamp to an unsigned 23-bit extent.
  function automatic logic [22:0] sat_u23(input logic signed [RW-1:0] v);
    if (v > Q8_MAX) begin
      return 23'h7FFFFF;
    end
    if (v < 0) begin
      return 23'd0;
    end
    return v[22:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sprite_quad_rotate_bounds.sv =====
// ----------------------------------------------------------------------------
// sprite_quad_rotate_bounds: screen bounding box of a rotated sprite quad
// Scales and rotates the sprite corners about Z, Y and X and returns the
// axis-aligned box in Q16.8.
//
//   Channel   Handshake          Payload
//   input     start / busy       in_sprite_present .. in_angle_z
//   result    out_valid strobe   out_box_min_x .. out_box_height
//
// One sprite per cycle is accepted; results leave in order. Each beat passes
// through a holding register and a two-entry queue into the ten-stage rotation
// pipeline, whose last stage raises its result strobe.
// Reset is synchronous and active low; it clears all valid flags.
// busy rises only if the queue is full; the queue drains every cycle, so busy
// stays low, and the result side cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none
module sprite_quad_rotate_bounds (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_sprite_present,
  input  wire logic [11:0]        in_sprite_width,
  input  wire logic [11:0]        in_sprite_height,
  input  wire logic [15:0]        in_scale_x,
  input  wire logic [15:0]        in_scale_y,
  input  wire logic signed [23:0] in_pos_x,
  input  wire logic signed [23:0] in_pos_y,
  input  wire logic [15:0]        in_angle_x,
  input  wire logic [15:0]        in_angle_y,
  input  wire logic [15:0]        in_angle_z,
  output logic                    out_valid,
  output logic signed [23:0]      out_box_min_x,
  output logic signed [23:0]      out_box_min_y,
  output logic [22:0]             out_box_width,
  output logic [22:0]             out_box_height
);
  import sqrb_pkg::*;

  logic    q_full, push, q_not_empty;
  q_item_t push_item, pop_item;

  // Front end: accept and classify.
  sqrb_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sprite_present(in_sprite_present),
    .in_sprite_width(in_sprite_width), .in_sprite_height(in_sprite_height),
    .in_scale_x(in_scale_x), .in_scale_y(in_scale_y),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_angle_x(in_angle_x), .in_angle_y(in_angle_y), .in_angle_z(in_angle_z),
    .q_full(q_full), .push(push), .push_item(push_item)
  );

  // Queue between the two halves.
  sqrb_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item),
    .full(q_full), .pop(1'b1), .not_empty(q_not_empty), .pop_item(pop_item)
  );

  // Back end: rotation and bounds.
  sqrb_back u_back (
    .clk(clk), .rst_n(rst_n), .in_valid(q_not_empty), .in_item(pop_item),
    .out_valid(out_valid), .out_box_min_x(out_box_min_x),
    .out_box_min_y(out_box_min_y), .out_box_width(out_box_width),
    .out_box_height(out_box_height)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/sqrb_front.sv =====
// ----------------------------------------------------------------------------
// sqrb_front: input stage
// Accepts a sprite beat, forms the scaled half extents and the six table
// addresses, and holds the beat until the queue can take it.
// ----------------------------------------------------------------------------
`default_nettype none
module sqrb_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   in_sprite_present,
  input  wire logic [11:0]            in_sprite_width,
  input  wire logic [11:0]            in_sprite_height,
  input  wire logic [15:0]            in_scale_x,
  input  wire logic [15:0]            in_scale_y,
  input  wire logic signed [23:0]     in_pos_x,
  input  wire logic signed [23:0]     in_pos_y,
  input  wire logic [15:0]            in_angle_x,
  input  wire logic [15:0]            in_angle_y,
  input  wire logic [15:0]            in_angle_z,
  input  wire logic                   q_full,
  output logic                        push,
  output sqrb_pkg::q_item_t           push_item
);
  import sqrb_pkg::*;

  logic    f_valid_r, f_valid_nxt;
  q_item_t f_item_r, f_item_nxt;
  logic    accept;

  // Accept when the held beat is empty or moving into the queue.
  assign push   = f_valid_r && !q_full;
  assign busy   = f_valid_r && q_full;
  assign accept = start && !busy;

  // Classify the incoming beat.
  always_comb begin
    f_item_nxt.present = in_sprite_present;
    f_item_nxt.hx      = HALF_W'(in_sprite_width) * HALF_W'(in_scale_x);
    f_item_nxt.hy      = HALF_W'(in_sprite_height) * HALF_W'(in_scale_y);
    f_item_nxt.px      = in_pos_x;
    f_item_nxt.py      = in_pos_y;
    f_item_nxt.sx      = trig_addr(in_angle_x);
    f_item_nxt.cx      = trig_addr(in_angle_x + 16'd16384);
    f_item_nxt.sy      = trig_addr(in_angle_y);
    f_item_nxt.cy      = trig_addr(in_angle_y + 16'd16384);
    f_item_nxt.sz      = trig_addr(in_angle_z);
    f_item_nxt.cz      = trig_addr(in_angle_z + 16'd16384);
    f_valid_nxt        = accept || (f_valid_r && !push);
  end

  // Holding register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
    if (accept) begin
      f_item_r <= f_item_nxt;
    end
  end

  assign push_item = f_item_r;

endmodule
`default_nettype wire

// ===== hw/rtl/sqrb_queue.sv =====
// ----------------------------------------------------------------------------
// sqrb_queue: two-entry queue between front and back
// Decouples the input stage from the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module sqrb_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire sqrb_pkg::q_item_t  push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    not_empty,
  output sqrb_pkg::q_item_t       pop_item
);
  import sqrb_pkg::*;

  q_item_t     mem_r [0:1];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sqrb_sine_rom.sv =====
// ----------------------------------------------------------------------------
// sqrb_sine_rom: quarter-wave sine ROM
// Two read ports with registered data, filled at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none
module sqrb_sine_rom (
  input  wire logic                       clk,
  input  wire logic [sqrb_pkg::IDX_W-1:0] addr_a,
  input  wire logic [sqrb_pkg::IDX_W-1:0] addr_b,
  output logic [16:0]                     data_a,
  output logic [16:0]                     data_b
);
  import sqrb_pkg::*;

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  logic [16:0] data_a_r;
  logic [16:0] data_b_r;

  // Registered reads.
  always_ff @(posedge clk) begin
    data_a_r <= SINE_TAB[addr_a];
    data_b_r <= SINE_TAB[addr_b];
  end

  assign data_a = data_a_r;
  assign data_b = data_b_r;

endmodule
`default_nettype wire

// ===== hw/rtl/sqrb_back.sv =====
// ----------------------------------------------------------------------------
// sqrb_back: rotation and bounds pipeline
// Looks up sines, rotates two corners (the other two are their negations),
// takes the box of all four and rounds and clamps it onto the result port.
// ----------------------------------------------------------------------------
`default_nettype none
module sqrb_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire sqrb_pkg::q_item_t  in_item,
  output logic                    out_valid,
  output logic signed [23:0]      out_box_min_x,
  output logic signed [23:0]      out_box_min_y,
  output logic [22:0]             out_box_width,
  output logic [22:0]             out_box_height
);
  import sqrb_pkg::*;

  typedef logic signed [TRIG_W-1:0] trig_t;

  // Valid flags of stages one through nine.
  logic [8:0] v_r;

  // Stage 1: table read in flight.
  logic                v1_present_r;
  logic [HALF_W-1:0]   v1_hx_r, v1_hy_r;
  logic signed [23:0]  v1_px_r, v1_py_r;
  logic [5:0]          v1_neg_r;
  logic [16:0]         rd_sx, rd_cx, rd_sy, rd_cy, rd_sz, rd_cz;

  // Stage 2: signed trig values.
  logic                v2_present_r;
  logic [HALF_W-1:0]   v2_hx_r, v2_hy_r;
  logic signed [23:0]  v2_px_r, v2_py_r;
  trig_t               sx2_r, cx2_r, sy2_r, cy2_r, sz2_r, cz2_r;

  // Stage 3: products of the half extents.
  logic                v3_present_r;
  logic signed [23:0]  v3_px_r, v3_py_r;
  trig_t               sx3_r, cx3_r, sy3_r, cy3_r;
  logic signed [46:0]  p_hxcz_r, p_hysz_r, p_hxsz_r, p_hycz_r;

  // Stage 4: corners after the Z turn.
  logic                v4_present_r;
  logic signed [23:0]  v4_px_r, v4_py_r;
  trig_t               sx4_r, cx4_r, sy4_r, cy4_r;
  logic signed [30:0]  x1a_r, y1a_r, x1b_r, y1b_r;

  // Stage 5: products with the Y and X angles.
  logic                v5_present_r;
  logic signed [23:0]  v5_px_r, v5_py_r;
  trig_t               sx5_r;
  logic signed [48:0]  xa_cy_r, xa_sy_r, ya_cx_r, xb_cy_r, xb_sy_r, yb_cx_r;

  // Stage 6: rounded Y-turn terms.
  logic                v6_present_r;
  logic signed [23:0]  v6_px_r, v6_py_r;
  trig_t               sx6_r;
  logic signed [31:0]  x3a6_r, x3b6_r;
  logic signed [30:0]  ta_r, tb_r;
  logic signed [48:0]  ya_cx6_r, yb_cx6_r;

  // Stage 7: second X-turn product.
  logic                v7_present_r;
  logic signed [23:0]  v7_px_r, v7_py_r;
  logic signed [31:0]  x3a7_r, x3b7_r;
  logic signed [48:0]  ya_cx7_r, yb_cx7_r, ta_sx_r, tb_sx_r;

  // Stage 8: final corner offsets.
  logic                v8_present_r;
  logic signed [23:0]  v8_px_r, v8_py_r;
  logic signed [31:0]  x3a8_r, x3b8_r, y3a8_r, y3b8_r;

  // Stage 9: box edges in Q.9.
  logic                v9_present_r;
  logic signed [33:0]  min_x_r, max_x_r, min_y_r, max_y_r;

  // Stage 10: result registers.
  logic                out_valid_r;
  logic signed [23:0]  out_min_x_r, out_min_y_r;
  logic [22:0]         out_width_r, out_height_r;

  // Combinational helpers.
  logic signed [HALF_W:0] hx_s, hy_s;
  logic signed [33:0]   px2, py2;
  logic signed [33:0]   wx [0:3];
  logic signed [33:0]   wy [0:3];
  logic signed [33:0]   mnx, mxx, mny, mxy;
  logic signed [RW-1:0] min_x_rnd, min_y_rnd, w_rnd, h_rnd;

  function automatic trig_t sign_trig(input logic neg, input logic [16:0] mag);
    trig_t t;
    t = $signed({1'b0, mag});
    return neg ? -t : t;
  endfunction

  // Three dual-read ROMs: one per rotation axis.
  sqrb_sine_rom u_rom_x (
    .clk(clk), .addr_a(in_item.sx.idx), .addr_b(in_item.cx.idx),
    .data_a(rd_sx), .data_b(rd_cx)
  );
  sqrb_sine_rom u_rom_y (
    .clk(clk), .addr_a(in_item.sy.idx), .addr_b(in_item.cy.idx),
    .data_a(rd_sy), .data_b(rd_cy)
  );
  sqrb_sine_rom u_rom_z (
    .clk(clk), .addr_a(in_item.sz.idx), .addr_b(in_item.cz.idx),
    .data_a(rd_sz), .data_b(rd_cz)
  );

  // Half extents as non-negative signed operands.
  assign hx_s = $signed({1'b0, v2_hx_r});
  assign hy_s = $signed({1'b0, v2_hy_r});

  // Four corners in Q.9: corners three and zero mirror corners one and two.
  always_comb begin
    px2   = 34'($signed({v8_px_r, 1'b0}));
    py2   = 34'($signed({v8_py_r, 1'b0}));
    wx[0] = px2 + 34'(x3a8_r);
    wx[1] = px2 - 34'(x3a8_r);
    wx[2] = px2 + 34'(x3b8_r);
    wx[3] = px2 - 34'(x3b8_r);
    wy[0] = py2 - 34'(y3a8_r);
    wy[1] = py2 + 34'(y3a8_r);
    wy[2] = py2 - 34'(y3b8_r);
    wy[3] = py2 + 34'(y3b8_r);
    mnx = (wx[0] < wx[1]) ? wx[0] : wx[1];
    mxx = (wx[0] > wx[1]) ? wx[0] : wx[1];
    mny = (wy[0] < wy[1]) ? wy[0] : wy[1];
    mxy = (wy[0] > wy[1]) ? wy[0] : wy[1];
    for (int i = 2; i < 4; i++) begin
      if (wx[i] < mnx) mnx = wx[i];
      if (wx[i] > mxx) mxx = wx[i];
      if (wy[i] < mny) mny = wy[i];
      if (wy[i] > mxy) mxy = wy[i];
    end
  end

  // Q.9 to Q.8 with rounding.
  assign min_x_rnd = rnd1(RW'(min_x_r));
  assign min_y_rnd = rnd1(RW'(min_y_r));
  assign w_rnd     = rnd1(RW'(max_x_r) - RW'(min_x_r));
  assign h_rnd     = rnd1(RW'(max_y_r) - RW'(min_y_r));

  // Stage valid chain; the back end never stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= {v_r[7:0], in_valid};
      out_valid_r <= v_r[8];
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    // Stage 1
    v1_present_r <= in_item.present;
    v1_hx_r      <= in_item.hx;
    v1_hy_r      <= in_item.hy;
    v1_px_r      <= in_item.px;
    v1_py_r      <= in_item.py;
    v1_neg_r     <= {in_item.sx.neg, in_item.cx.neg, in_item.sy.neg,
                     in_item.cy.neg, in_item.sz.neg, in_item.cz.neg};
    // Stage 2
    v2_present_r <= v1_present_r;
    v2_hx_r      <= v1_hx_r;
    v2_hy_r      <= v1_hy_r;
    v2_px_r      <= v1_px_r;
    v2_py_r      <= v1_py_r;
    sx2_r        <= sign_trig(v1_neg_r[5], rd_sx);
    cx2_r        <= sign_trig(v1_neg_r[4], rd_cx);
    sy2_r        <= sign_trig(v1_neg_r[3], rd_sy);
    cy2_r        <= sign_trig(v1_neg_r[2], rd_cy);
    sz2_r        <= sign_trig(v1_neg_r[1], rd_sz);
    cz2_r        <= sign_trig(v1_neg_r[0], rd_cz);
    // Stage 3
    v3_present_r <= v2_present_r;
    v3_px_r      <= v2_px_r;
    v3_py_r      <= v2_py_r;
    sx3_r        <= sx2_r;
    cx3_r        <= cx2_r;
    sy3_r        <= sy2_r;
    cy3_r        <= cy2_r;
    p_hxcz_r     <= 47'(hx_s * cz2_r);
    p_hysz_r     <= 47'(hy_s * sz2_r);
    p_hxsz_r     <= 47'(hx_s * sz2_r);
    p_hycz_r     <= 47'(hy_s * cz2_r);
    // Stage 4
    v4_present_r <= v3_present_r;
    v4_px_r      <= v3_px_r;
    v4_py_r      <= v3_py_r;
    sx4_r        <= sx3_r;
    cx4_r        <= cx3_r;
    sy4_r        <= sy3_r;
    cy4_r        <= cy3_r;
    x1a_r        <= 31'(rnd16(RW'(p_hxcz_r) - RW'(p_hysz_r)));
    y1a_r        <= 31'(rnd16(RW'(p_hxsz_r) + RW'(p_hycz_r)));
    x1b_r        <= 31'(rnd16(RW'(p_hxcz_r) + RW'(p_hysz_r)));
    y1b_r        <= 31'(rnd16(RW'(p_hxsz_r) - RW'(p_hycz_r)));
    // Stage 5
    v5_present_r <= v4_present_r;
    v5_px_r      <= v4_px_r;
    v5_py_r      <= v4_py_r;
    sx5_r        <= sx4_r;
    xa_cy_r      <= 49'(x1a_r * cy4_r);
    xa_sy_r      <= 49'(x1a_r * sy4_r);
    ya_cx_r      <= 49'(y1a_r * cx4_r);
    xb_cy_r      <= 49'(x1b_r * cy4_r);
    xb_sy_r      <= 49'(x1b_r * sy4_r);
    yb_cx_r      <= 49'(y1b_r * cx4_r);
    // Stage 6
    v6_present_r <= v5_present_r;
    v6_px_r      <= v5_px_r;
    v6_py_r      <= v5_py_r;
    sx6_r        <= sx5_r;
    x3a6_r       <= 32'(rnd16(RW'(xa_cy_r)));
    x3b6_r       <= 32'(rnd16(RW'(xb_cy_r)));
    ta_r         <= 31'(rnd16(RW'(xa_sy_r)));
    tb_r         <= 31'(rnd16(RW'(xb_sy_r)));
    ya_cx6_r     <= ya_cx_r;
    yb_cx6_r     <= yb_cx_r;
    // Stage 7
    v7_present_r <= v6_present_r;
    v7_px_r      <= v6_px_r;
    v7_py_r      <= v6_py_r;
    x3a7_r       <= x3a6_r;
    x3b7_r       <= x3b6_r;
    ya_cx7_r     <= ya_cx6_r;
    yb_cx7_r     <= yb_cx6_r;
    ta_sx_r      <= 49'(ta_r * sx6_r);
    tb_sx_r      <= 49'(tb_r * sx6_r);
    // Stage 8
    v8_present_r <= v7_present_r;
    v8_px_r      <= v7_px_r;
    v8_py_r      <= v7_py_r;
    x3a8_r       <= x3a7_r;
    x3b8_r       <= x3b7_r;
    y3a8_r       <= 32'(rnd16(RW'(ya_cx7_r) + RW'(ta_sx_r)));
    y3b8_r       <= 32'(rnd16(RW'(yb_cx7_r) + RW'(tb_sx_r)));
    // Stage 9
    v9_present_r <= v8_present_r;
    min_x_r      <= mnx;
    max_x_r      <= mxx;
    min_y_r      <= mny;
    max_y_r      <= mxy;
    // Stage 10: an absent sprite gives an all-zero box.
    out_min_x_r  <= v9_present_r ? $signed(sat_s24(min_x_rnd)) : 24'sd0;
    out_min_y_r  <= v9_present_r ? $signed(sat_s24(min_y_rnd)) : 24'sd0;
    out_width_r  <= v9_present_r ? sat_u23(w_rnd) : 23'd0;
    out_height_r <= v9_present_r ? sat_u23(h_rnd) : 23'd0;
  end

  assign out_valid      = out_valid_r;
  assign out_box_min_x  = out_min_x_r;
  assign out_box_min_y  = out_min_y_r;
  assign out_box_width  = out_width_r;
  assign out_box_height = out_height_r;

endmodule
`default_nettype wire

// ===== bench/tb_sprite_quad_rotate_bounds.sv =====
// ----------------------------------------------------------------------------
// tb_sprite_quad_rotate_bounds: self-checking bench for the sprite box block
// Drives sprite beats through the start/busy handshake with random gaps,
// predicts each bounding box with a local fixed-point model of the scale,
// three-axis rotation and clamp, and compares every out_valid beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_sprite_quad_rotate_bounds;
  import sqrb_pkg::*;

  localparam int DEPTH = sqrb_pkg::SINE_TABLE_DEPTH;

  typedef struct packed {
    logic               present;
    logic [11:0]        width;
    logic [11:0]        height;
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0]        ang_x;
    logic [15:0]        ang_y;
    logic [15:0]        ang_z;
  } sprite_t;

  typedef struct packed {
    logic signed [23:0] min_x;
    logic signed [23:0] min_y;
    logic [22:0]        width;
    logic [22:0]        height;
  } box_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  sprite_t drv = '0;
  logic out_valid;
  box_t got;

  sprite_t pending_sprites[$];
  box_t    expected_boxes[$];
  longint  quarter_sine[0:DEPTH];
  int      mismatches = 0;
  int      boxes_checked = 0;
  int      sprites_sent = 0;
  bit      stimulus_done = 1'b0;
  int      quiet_from = 0;
  int      quiet_to = 0;
  int      cycle_count = 0;

  always #4 clk = ~clk;

  sprite_quad_rotate_bounds dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sprite_present(drv.present), .in_sprite_width(drv.width),
    .in_sprite_height(drv.height), .in_scale_x(drv.scale_x),
    .in_scale_y(drv.scale_y), .in_pos_x(drv.pos_x), .in_pos_y(drv.pos_y),
    .in_angle_x(drv.ang_x), .in_angle_y(drv.ang_y), .in_angle_z(drv.ang_z),
    .out_valid(out_valid), .out_box_min_x(got.min_x), .out_box_min_y(got.min_y),
    .out_box_width(got.width), .out_box_height(got.height)
  );

  // Quarter-wave sine in Q.16 from a Q30 series through the 15th power.
  function automatic void fill_sine();
    longint unsigned x, x2, term, sum, q;
    for (int k = 0; k <= DEPTH; k++) begin
      x = (64'd1686629713 * longint'(k)) / DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        sum = (n % 2 == 1) ? sum - term : sum + term;
      end
      q = (sum + 64'd8192) >> 14;
      quarter_sine[k] = (q > 64'd65536) ? 65536 : longint'(q);
    end
  endfunction

  function automatic longint sine_of(input logic [15:0] a);
    int idx;
    idx = (int'(a[13:0]) * DEPTH) >> 14;
    case (a[15:14])
      2'd0: return quarter_sine[idx];
      2'd1: return quarter_sine[DEPTH - idx];
      2'd2: return -quarter_sine[idx];
      default: return -quarter_sine[DEPTH - idx];
    endcase
  endfunction

  function automatic longint round_away(input longint v, input int n);
    longint half;
    half = longint'(1) << (n - 1);
    if (v >= 0) return (v + half) >>> n;
    return -((-v + half) >>> n);
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Bounding box of the four scaled, rotated corners, Y flipped for screen.
  function automatic box_t predict_box(input sprite_t s);
    box_t b;
    longint hx, hy, px, py, sx, cx, sy, cy, sz, cz;
    longint x, y, x1, y1, x3, y3, wx, wy;
    longint lo_x, hi_x, lo_y, hi_y;
    b = '0;
    if (!s.present) return b;
    hx = longint'(s.width) * longint'(s.scale_x);
    hy = longint'(s.height) * longint'(s.scale_y);
    px = longint'(s.pos_x) * 2;
    py = longint'(s.pos_y) * 2;
    sx = sine_of(s.ang_x);
    cx = sine_of(s.ang_x + 16'd16384);
    sy = sine_of(s.ang_y);
    cy = sine_of(s.ang_y + 16'd16384);
    sz = sine_of(s.ang_z);
    cz = sine_of(s.ang_z + 16'd16384);
    lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
    for (int i = 0; i < 4; i++) begin
      x = (i == 0 || i == 3) ? -hx : hx;
      y = (i < 2) ? hy : -hy;
      x1 = round_away(x * cz - y * sz, 16);
      y1 = round_away(x * sz + y * cz, 16);
      x3 = round_away(x1 * cy, 16);
      y3 = round_away(y1 * cx + round_away(x1 * sy, 16) * sx, 16);
      wx = px + x3;
      wy = py - y3;
      if (i == 0 || wx < lo_x) lo_x = wx;
      if (i == 0 || wx > hi_x) hi_x = wx;
      if (i == 0 || wy < lo_y) lo_y = wy;
      if (i == 0 || wy > hi_y) hi_y = wy;
    end
    b.min_x = 24'(clamp(round_away(lo_x, 1), -8388608, 8388607));
    b.min_y = 24'(clamp(round_away(lo_y, 1), -8388608, 8388607));
    b.width = 23'(clamp(round_away(hi_x - lo_x, 1), 0, 8388607));
    b.height = 23'(clamp(round_away(hi_y - lo_y, 1), 0, 8388607));
    return b;
  endfunction

  function automatic sprite_t random_sprite();
    sprite_t s;
    s.present = ($urandom_range(0, 9) != 0);
    s.width = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 255));
    s.height = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 255));
    s.scale_x = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
    s.scale_y = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
    s.pos_x = 24'($urandom);
    s.pos_y = 24'($urandom);
    s.ang_x = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 3) << 14) : 16'($urandom);
    s.ang_y = 16'($urandom);
    s.ang_z = 16'($urandom);
    return s;
  endfunction

  // Driver: a beat moves when start is high and busy is low at the edge.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (start && !busy) begin
        expected_boxes.push_back(predict_box(drv));
        sprites_sent <= sprites_sent + 1;
      end
      if (start && busy) begin
        // Hold the beat until it is taken.
      end else if (pending_sprites.size() > 0 &&
                   ((cycle_count >= quiet_from && cycle_count < quiet_to) ||
                    $urandom_range(0, 99) >= 8)) begin
        start <= 1'b1;
        drv <= pending_sprites.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each strobe is checked against the oldest predicted box.
  always @(posedge clk) begin
    box_t want;
    if (rst_n && out_valid) begin
      if (expected_boxes.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected box beat %h", got);
      end else begin
        want = expected_boxes.pop_front();
        boxes_checked <= boxes_checked + 1;
        if (want !== got) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("box %0d: expected x %0d y %0d w %0d h %0d, got x %0d y %0d w %0d h %0d",
                     boxes_checked, want.min_x, want.min_y, want.width, want.height,
                     got.min_x, got.min_y, got.width, got.height);
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    sprite_t s;
    fill_sine();
    quiet_from = 2000;
    quiet_to = 2400;
    // Directed: absent sprite, degenerate sizes, extremes, quadrant angles.
    s = '0;
    pending_sprites.push_back(s);
    s = '1; s.present = 1'b0;
    pending_sprites.push_back(s);
    s = '0; s.present = 1'b1; s.pos_x = 24'sd1000; s.pos_y = -24'sd1000;
    pending_sprites.push_back(s);
    s.width = 12'd16; s.height = 12'd16; s.scale_x = 16'd0; s.scale_y = 16'd0;
    pending_sprites.push_back(s);
    s.scale_x = 16'd256; s.scale_y = 16'd256;
    for (int q = 0; q < 4; q++) begin
      s.ang_z = 16'(q << 14); s.ang_y = 16'd0; s.ang_x = 16'd0;
      pending_sprites.push_back(s);
      s.ang_z = 16'd0; s.ang_y = 16'(q << 14);
      pending_sprites.push_back(s);
      s.ang_y = 16'd0; s.ang_x = 16'(q << 14);
      pending_sprites.push_back(s);
    end
    s = '1; s.pos_x = 24'sh7FFFFF; s.pos_y = 24'sh7FFFFF;
    pending_sprites.push_back(s);
    s.pos_x = 24'sh800000; s.pos_y = 24'sh800000; s.ang_x = 16'h2000;
    pending_sprites.push_back(s);
    s.ang_x = 16'h1234; s.ang_y = 16'hABCD; s.ang_z = 16'h8001; s.pos_x = '0;
    pending_sprites.push_back(s);
    s = '0; s.present = 1'b1; s.width = 12'd1; s.height = 12'd1;
    s.scale_x = 16'd1; s.scale_y = 16'd1; s.ang_z = 16'd8192;
    pending_sprites.push_back(s);
    for (int i = 0; i < 1050; i++) pending_sprites.push_back(random_sprite());
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_sprites.size() > 0 || start) @(posedge clk);
    stimulus_done = 1'b1;
    while (expected_boxes.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Checked %0d bounding boxes from %0d sprite beats,", boxes_checked, sprites_sent);
    $display("covering absent sprites, zero sizes, quadrant angles and saturation.");
    if (mismatches == 0 && expected_boxes.size() == 0) begin
      $display("PASS sprite_quad_rotate_bounds");
    end else begin
      $display("FAIL sprite_quad_rotate_bounds");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #2000000;
    $display("FAIL sprite_quad_rotate_bounds");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sprite_quad_rotate_bounds.f =====
hw/rtl/sqrb_pkg.sv
hw/rtl/sqrb_front.sv
hw/rtl/sqrb_queue.sv
hw/rtl/sqrb_sine_rom.sv
hw/rtl/sqrb_back.sv
hw/rtl/sprite_quad_rotate_bounds.sv
bench/tb_sprite_quad_rotate_bounds.sv
